[rtl/entd_pkg.sv]
// Shared types and constants for the escaped node tree deframer.
// Used by entd_core, entd_resq and escaped_node_tree_deframer; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package entd_pkg;

  localparam int MAX_DEPTH_DEF = 64;
  localparam int DEPTH_W       = 7;
  localparam int RESQ_DEPTH    = 4;
  localparam int CFG_IDX_W     = 2;

  typedef enum logic [1:0] {
    EV_OPEN   = 2'd0,
    EV_CLOSE  = 2'd1,
    EV_PROP   = 2'd2,
    EV_STATUS = 2'd3
  } event_t;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_ID     = 3'd1;
  localparam logic [2:0] ST_NO_START   = 3'd2;
  localparam logic [2:0] ST_UNBALANCED = 3'd3;
  localparam logic [2:0] ST_TRUNCATED  = 3'd4;
  localparam logic [2:0] ST_UNCLOSED   = 3'd5;
  localparam logic [2:0] ST_SHORT_DEEP = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_ACCEPTED_ID   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_MARKER = 2'd3;

  localparam logic [31:0] ACCEPTED_ID_RST   = 32'd0;
  localparam logic [7:0]  START_MARKER_RST  = 8'd254;
  localparam logic [7:0]  END_MARKER_RST    = 8'd255;
  localparam logic [7:0]  ESCAPE_MARKER_RST = 8'd253;

  typedef struct packed {
    logic [31:0] accepted_id;
    logic [7:0]  start_marker;
    logic [7:0]  end_marker;
    logic [7:0]  escape_marker;
  } cfg_t;

  typedef struct packed {
    event_t             event_res;
    logic [7:0]         node_type;
    logic [DEPTH_W-1:0] depth;
    logic [7:0]         value;
    logic [2:0]         status;
    logic               last;
  } res_t;

  // Up to two results per byte: res_a goes first, res_b second.
  typedef struct packed {
    logic [1:0] count;
    res_t       res_a;
    res_t       res_b;
  } push_t;

endpackage

`default_nettype wire

[rtl/entd_core.sv]
// Parser for one byte per cycle while go is high: header check, nesting tracker and error logic.
// Depends on entd_pkg for the result, push and configuration types.
`timescale 1ns / 1ps
`default_nettype none

module entd_core #(
  parameter int MAX_DEPTH = entd_pkg::MAX_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          go,
  input  wire logic [7:0]    byte_in,
  input  wire logic          eof_in,
  input  wire entd_pkg::cfg_t cfg,
  output entd_pkg::push_t    push
);

  localparam int DW = $clog2(MAX_DEPTH + 1);

  logic [31:0]   id_shift, id_shift_next;
  logic [3:0]    byte_count, byte_count_next;
  logic [DW-1:0] nest_depth, nest_depth_next;
  logic          expect_type, expect_type_next;
  logic          escape_pending, escape_pending_next;
  logic          in_props, in_props_next;
  logic [2:0]    error_code, error_code_next;

  logic                         has_ev;
  entd_pkg::event_t             ev_code;
  logic [7:0]                   ev_type;
  logic [7:0]                   ev_value;
  logic [2:0]                   st;
  logic [DW+entd_pkg::DEPTH_W-1:0] depth_ext;
  entd_pkg::res_t               ev_res, st_res;

  always_comb begin
    id_shift_next       = id_shift;
    byte_count_next     = (byte_count == 4'd15) ? byte_count : byte_count + 4'd1;
    nest_depth_next     = nest_depth;
    expect_type_next    = expect_type;
    escape_pending_next = escape_pending;
    in_props_next       = in_props;
    error_code_next     = error_code;
    has_ev              = 1'b0;
    ev_code             = entd_pkg::EV_PROP;
    ev_type             = 8'd0;
    ev_value            = 8'd0;

    if (error_code == entd_pkg::ST_OK) begin
      if (byte_count < 4'd4) begin
        id_shift_next = {id_shift[23:0], byte_in};
        if (byte_count == 4'd3 && id_shift_next != cfg.accepted_id &&
            id_shift_next != 32'd0) begin
          error_code_next = entd_pkg::ST_BAD_ID;
        end
      end else if (byte_count == 4'd4) begin
        if (byte_in != cfg.start_marker) begin
          error_code_next = entd_pkg::ST_NO_START;
        end
      end else if (byte_count == 4'd5) begin
        nest_depth_next = DW'(1);
        in_props_next   = 1'b1;
        has_ev          = 1'b1;
        ev_code         = entd_pkg::EV_OPEN;
        ev_type         = byte_in;
      end else if (escape_pending) begin
        escape_pending_next = 1'b0;
        if (in_props) begin
          has_ev   = 1'b1;
          ev_value = byte_in;
        end
      end else if (expect_type) begin
        expect_type_next = 1'b0;
        in_props_next    = 1'b1;
        has_ev           = 1'b1;
        ev_code          = entd_pkg::EV_OPEN;
        ev_type          = byte_in;
      end else if (byte_in == cfg.start_marker) begin
        if (nest_depth == '0) begin
          error_code_next = entd_pkg::ST_UNBALANCED;
        end else if (nest_depth == DW'(MAX_DEPTH)) begin
          error_code_next = entd_pkg::ST_SHORT_DEEP;
        end else begin
          nest_depth_next  = nest_depth + DW'(1);
          expect_type_next = 1'b1;
          in_props_next    = 1'b0;
        end
      end else if (byte_in == cfg.end_marker) begin
        if (nest_depth == '0) begin
          error_code_next = entd_pkg::ST_UNBALANCED;
        end else begin
          nest_depth_next = nest_depth - DW'(1);
          in_props_next   = 1'b0;
          has_ev          = 1'b1;
          ev_code         = entd_pkg::EV_CLOSE;
        end
      end else if (byte_in == cfg.escape_marker) begin
        escape_pending_next = 1'b1;
      end else if (in_props) begin
        has_ev   = 1'b1;
        ev_value = byte_in;
      end
    end

    // The short-file check wins over every other error.
    if (byte_count_next <= 4'd7) begin
      st = entd_pkg::ST_SHORT_DEEP;
    end else if (error_code_next != entd_pkg::ST_OK) begin
      st = error_code_next;
    end else if (escape_pending_next || expect_type_next) begin
      st = entd_pkg::ST_TRUNCATED;
    end else if (nest_depth_next != '0) begin
      st = entd_pkg::ST_UNCLOSED;
    end else begin
      st = entd_pkg::ST_OK;
    end
  end

  // The depth field carries the low bits of the nesting count.
  assign depth_ext = {{entd_pkg::DEPTH_W{1'b0}}, nest_depth_next};

  always_comb begin
    ev_res.event_res = ev_code;
    ev_res.node_type = ev_type;
    ev_res.depth     = depth_ext[entd_pkg::DEPTH_W-1:0];
    ev_res.value     = ev_value;
    ev_res.status    = entd_pkg::ST_OK;
    ev_res.last      = 1'b0;

    st_res.event_res = entd_pkg::EV_STATUS;
    st_res.node_type = 8'd0;
    st_res.depth     = depth_ext[entd_pkg::DEPTH_W-1:0];
    st_res.value     = 8'd0;
    st_res.status    = st;
    st_res.last      = 1'b1;

    push.count = go ? ({1'b0, has_ev} + {1'b0, eof_in}) : 2'd0;
    push.res_a = has_ev ? ev_res : st_res;
    push.res_b = st_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id_shift       <= '0;
      byte_count     <= '0;
      nest_depth     <= '0;
      expect_type    <= 1'b0;
      escape_pending <= 1'b0;
      in_props       <= 1'b0;
      error_code     <= entd_pkg::ST_OK;
    end else if (go) begin
      if (eof_in) begin
        // The status result closes the file; the next byte starts a new one.
        id_shift       <= '0;
        byte_count     <= '0;
        nest_depth     <= '0;
        expect_type    <= 1'b0;
        escape_pending <= 1'b0;
        in_props       <= 1'b0;
        error_code     <= entd_pkg::ST_OK;
      end else begin
        id_shift       <= id_shift_next;
        byte_count     <= byte_count_next;
        nest_depth     <= nest_depth_next;
        expect_type    <= expect_type_next;
        escape_pending <= escape_pending_next;
        in_props       <= in_props_next;
        error_code     <= error_code_next;
      end
    end
  end

  a_eof_clears: assert property (@(posedge clk) disable iff (rst)
    go && eof_in |=> byte_count == '0 && nest_depth == '0 && error_code == entd_pkg::ST_OK)
    else $error("file state not cleared after final byte");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    nest_depth <= DW'(MAX_DEPTH))
    else $error("nesting depth above bound");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    go && !eof_in && error_code != entd_pkg::ST_OK |=> error_code == $past(error_code))
    else $error("error code changed within a file");

  a_error_silent: assert property (@(posedge clk) disable iff (rst)
    go && error_code != entd_pkg::ST_OK |-> push.count == {1'b0, eof_in})
    else $error("event produced after an error");

endmodule

`default_nettype wire

[rtl/entd_resq.sv]
// Result queue: takes up to two result words per cycle and hands out one.
// Depends on entd_pkg for the result and push types and the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module entd_resq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire entd_pkg::push_t push,
  input  wire logic           pop,
  output logic                room,
  output logic                res_valid,
  output entd_pkg::res_t      res
);

  localparam int PW = $clog2(entd_pkg::RESQ_DEPTH);
  localparam int CW = $clog2(entd_pkg::RESQ_DEPTH + 1);

  entd_pkg::res_t mem [entd_pkg::RESQ_DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count, count_next;
  logic           pop_ok;

  assign pop_ok    = pop && count != '0;
  assign res_valid = count != '0;
  assign res       = mem[rd_ptr];
  // Room for the worst case of two words, judged before this cycle's pop.
  assign room      = count <= CW'(entd_pkg::RESQ_DEPTH - 2);
  assign count_next = count + CW'(push.count) - CW'(pop_ok);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.res_a;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + PW'(1)] <= push.res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.count);
      rd_ptr <= rd_ptr + PW'(pop_ok);
      count  <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> room)
    else $error("result queue written without room");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(entd_pkg::RESQ_DEPTH))
    else $error("result queue count out of range");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd0 && !pop_ok |=> count == $past(count))
    else $error("result queue count moved while idle");

endmodule

`default_nettype wire

[rtl/escaped_node_tree_deframer.sv]
// Top level of the escaped node tree deframer: ports, registers, input stage.
// Depends on entd_pkg, entd_core and entd_resq.
`timescale 1ns / 1ps
`default_nettype none

// Takes a file one byte per word and reports node open, node close and property
// byte events, followed by one status word with the file's final byte. A byte is
// accepted every cycle while in_stall is low; its results pass through the input
// register and then the result queue. The output side drains one word per cycle
// while out_stall is low, so the two words that the final byte of a file can
// cause are absorbed by the four-word result queue. Write the configuration
// registers only while no file is in progress and all results have been taken.
// The nesting bound is MAX_DEPTH; depth reports its low seven bits.
module escaped_node_tree_deframer #(
  parameter int MAX_DEPTH = entd_pkg::MAX_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    data_byte,
  input  wire logic                          end_of_file,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         event_res,
  output logic [7:0]                         node_type,
  output logic [entd_pkg::DEPTH_W-1:0]       depth,
  output logic [7:0]                         value,
  output logic [2:0]                         status,
  output logic                               last,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [entd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);

  entd_pkg::cfg_t  cfg;
  entd_pkg::push_t push;
  entd_pkg::res_t  res;

  logic       in_v;
  logic [7:0] in_byte;
  logic       in_eof;
  logic       room;
  logic       go;
  logic       accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accepted_id   <= entd_pkg::ACCEPTED_ID_RST;
      cfg.start_marker  <= entd_pkg::START_MARKER_RST;
      cfg.end_marker    <= entd_pkg::END_MARKER_RST;
      cfg.escape_marker <= entd_pkg::ESCAPE_MARKER_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        entd_pkg::REG_ACCEPTED_ID:   cfg.accepted_id   <= cfg_data;
        entd_pkg::REG_START_MARKER:  cfg.start_marker  <= cfg_data[7:0];
        entd_pkg::REG_END_MARKER:    cfg.end_marker    <= cfg_data[7:0];
        entd_pkg::REG_ESCAPE_MARKER: cfg.escape_marker <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // The input register moves on whenever the queue can take two words.
  assign go       = in_v && room;
  assign in_stall = in_v && !room;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= accept || (in_v && !go);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= data_byte;
      in_eof  <= end_of_file;
    end
  end

  entd_core #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .go      (go),
    .byte_in (in_byte),
    .eof_in  (in_eof),
    .cfg     (cfg),
    .push    (push)
  );

  entd_resq u_resq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (!out_stall),
    .room      (room),
    .res_valid (out_valid),
    .res       (res)
  );

  assign event_res = res.event_res;
  assign node_type = res.node_type;
  assign depth     = res.depth;
  assign value     = res.value;
  assign status    = res.status;
  assign last      = res.last;

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for escaped_node_tree_deframer: random files of bytes in,
// node and status words out, checked against a cycle-free predictor kept in step.
// Depends on entd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module tb;
  import entd_pkg::*;

  localparam int MAX_DEPTH   = MAX_DEPTH_DEF;
  localparam int IDLE_LIMIT  = 4000;
  localparam int PHASE_BYTES = 58;

  typedef struct {
    logic [7:0] b;
    logic       eof;
    logic       hold;
  } byte_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic [7:0]           data_byte   = 8'h00;
  logic                 end_of_file = 1'b0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [1:0]           event_res;
  logic [7:0]           node_type;
  logic [DEPTH_W-1:0]   depth;
  logic [7:0]           value;
  logic [2:0]           status;
  logic                 last;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [31:0]          cfg_data    = '0;

  escaped_node_tree_deframer #(.MAX_DEPTH(MAX_DEPTH)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .end_of_file(end_of_file),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_res(event_res), .node_type(node_type), .depth(depth),
    .value(value), .status(status), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor copy of the registers and of the per-file tracking state.
  cfg_t        cur_cfg = '{ACCEPTED_ID_RST, START_MARKER_RST, END_MARKER_RST,
                           ESCAPE_MARKER_RST};
  logic [31:0] trk_id = '0;
  logic [3:0]  trk_count = '0;
  logic [6:0]  trk_nest = '0;
  logic        trk_type_next = 1'b0;
  logic        trk_esc = 1'b0;
  logic        trk_props = 1'b0;
  logic [2:0]  trk_err = ST_OK;

  res_t       expected_events[$];
  byte_item_t pending_bytes[$];
  logic [7:0] file_buf[$];
  int         queued_cnt = 0;
  int         n_errors = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (n_errors < 50)
      $display("ERROR @%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    n_errors++;
  endtask

  task automatic push_event(input event_t ev, input logic [7:0] ty, input logic [7:0] val,
                            input logic [2:0] st, input logic lst);
    res_t r;
    r.event_res = ev;
    r.node_type = ty;
    r.depth     = trk_nest;
    r.value     = val;
    r.status    = st;
    r.last      = lst;
    expected_events.push_back(r);
  endtask

  // Advances the file tracking state by one accepted byte and queues its words.
  task automatic predict_events(input logic [7:0] b, input logic eof);
    logic [3:0] pos;
    logic [2:0] st;
    pos = trk_count;
    if (trk_count < 4'd15) trk_count++;
    if (trk_err == ST_OK) begin
      if (pos < 4) begin
        trk_id = {trk_id[23:0], b};
        if (pos == 3 && trk_id != cur_cfg.accepted_id && trk_id != 32'd0)
          trk_err = ST_BAD_ID;
      end else if (pos == 4) begin
        if (b != cur_cfg.start_marker) trk_err = ST_NO_START;
      end else if (pos == 5) begin
        trk_nest  = 7'd1;
        trk_props = 1'b1;
        push_event(EV_OPEN, b, 8'h00, ST_OK, 1'b0);
      end else if (trk_esc) begin
        trk_esc = 1'b0;
        if (trk_props) push_event(EV_PROP, 8'h00, b, ST_OK, 1'b0);
      end else if (trk_type_next) begin
        trk_type_next = 1'b0;
        trk_props     = 1'b1;
        push_event(EV_OPEN, b, 8'h00, ST_OK, 1'b0);
      end else if (b == cur_cfg.start_marker) begin
        if (trk_nest == 0) trk_err = ST_UNBALANCED;
        else if (trk_nest >= MAX_DEPTH) trk_err = ST_SHORT_DEEP;
        else begin
          trk_nest++;
          trk_type_next = 1'b1;
          trk_props     = 1'b0;
        end
      end else if (b == cur_cfg.end_marker) begin
        if (trk_nest == 0) trk_err = ST_UNBALANCED;
        else begin
          trk_nest--;
          trk_props = 1'b0;
          push_event(EV_CLOSE, 8'h00, 8'h00, ST_OK, 1'b0);
        end
      end else if (b == cur_cfg.escape_marker) begin
        trk_esc = 1'b1;
      end else if (trk_props) begin
        push_event(EV_PROP, 8'h00, b, ST_OK, 1'b0);
      end
    end
    if (eof) begin
      if (trk_count <= 4'd7) st = ST_SHORT_DEEP;
      else if (trk_err != ST_OK) st = trk_err;
      else if (trk_esc || trk_type_next) st = ST_TRUNCATED;
      else if (trk_nest != 0) st = ST_UNCLOSED;
      else st = ST_OK;
      push_event(EV_STATUS, 8'h00, 8'h00, st, 1'b1);
      trk_id        = '0;
      trk_count     = '0;
      trk_nest      = '0;
      trk_type_next = 1'b0;
      trk_esc       = 1'b0;
      trk_props     = 1'b0;
      trk_err       = ST_OK;
    end
  endtask

  // Mostly no gap or a short one, now and then a long one, and runs with none at all.
  function automatic int draw_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) calm = $urandom_range(20, 60);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Driver: one word per accepted handshake, fed from pending_bytes.
  logic       drv_next_valid;
  int         drv_gap = 0;
  int         drv_calm = 0;
  byte_item_t drv_item;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      drv_next_valid = in_valid;
      if (in_valid && !in_stall) begin
        predict_events(data_byte, end_of_file);
        drv_next_valid = 1'b0;
        drv_gap = draw_gap(drv_calm);
      end
      if (!drv_next_valid) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (pending_bytes.size() != 0 &&
                     !(pending_bytes[0].hold && expected_events.size() != 0)) begin
          drv_item = pending_bytes.pop_front();
          data_byte   <= drv_item.b;
          end_of_file <= drv_item.eof;
          drv_next_valid = 1'b1;
        end
      end
      in_valid <= drv_next_valid;
    end
  end

  // Monitor: checks every accepted word against the oldest expected word.
  res_t mon_want;
  int   mon_stall = 0;
  int   mon_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          report_mismatch("unexpected word, event_res", int'(event_res), 0);
        end else begin
          mon_want = expected_events.pop_front();
          if (event_res != mon_want.event_res)
            report_mismatch("event_res", int'(event_res), int'(mon_want.event_res));
          if (node_type != mon_want.node_type)
            report_mismatch("node_type", int'(node_type), int'(mon_want.node_type));
          if (depth != mon_want.depth)
            report_mismatch("depth", int'(depth), int'(mon_want.depth));
          if (value != mon_want.value)
            report_mismatch("value", int'(value), int'(mon_want.value));
          if (status != mon_want.status)
            report_mismatch("status", int'(status), int'(mon_want.status));
          if (last != mon_want.last)
            report_mismatch("last", int'(last), int'(mon_want.last));
        end
      end
      if (mon_stall > 0) begin
        mon_stall--;
        out_stall <= 1'b1;
      end else begin
        mon_stall = draw_gap(mon_calm);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any handshake.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("** escaped_node_tree_deframer: FAILED **");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ACCEPTED_ID:   cur_cfg.accepted_id   = val;
      REG_START_MARKER:  cur_cfg.start_marker  = val[7:0];
      REG_END_MARKER:    cur_cfg.end_marker    = val[7:0];
      REG_ESCAPE_MARKER: cur_cfg.escape_marker = val[7:0];
      default: ;
    endcase
  endtask

  // The check runs just after the edge, once the driver and monitor have moved on.
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_bytes.size() != 0 || in_valid || expected_events.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic add_byte(input logic [7:0] b);
    file_buf.push_back(b);
  endtask

  // Moves the file being built into the send queue, flagging its final byte.
  task automatic flush_file();
    byte_item_t it;
    for (int i = 0; i < file_buf.size(); i++) begin
      it.b    = file_buf[i];
      it.eof  = (i == file_buf.size() - 1);
      it.hold = ($urandom_range(0, 99) == 0);
      pending_bytes.push_back(it);
      queued_cnt++;
    end
    file_buf.delete();
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255));
    while (v == cur_cfg.start_marker || v == cur_cfg.end_marker ||
           v == cur_cfg.escape_marker);
    return v;
  endfunction

  // Mostly well-formed files with random content; some are short, carry a wrong
  // header, close too much or stop in the middle of an escape or a child.
  task automatic gen_file(input int body_len);
    int          lvl;
    int          a;
    logic [31:0] id;
    if ($urandom_range(0, 99) < 5) begin
      repeat ($urandom_range(1, 7)) add_byte(8'($urandom_range(0, 255)));
    end else begin
      a = $urandom_range(0, 99);
      if (a < 60) id = cur_cfg.accepted_id;
      else if (a < 80) id = 32'd0;
      else id = $urandom;
      add_byte(id[31:24]);
      add_byte(id[23:16]);
      add_byte(id[15:8]);
      add_byte(id[7:0]);
      if ($urandom_range(0, 99) < 5) add_byte(8'($urandom_range(0, 255)));
      else add_byte(cur_cfg.start_marker);
      add_byte(8'($urandom_range(0, 255)));
      lvl = 1;
      for (int i = 0; i < body_len; i++) begin
        a = $urandom_range(0, 99);
        if (a < 40) begin
          add_byte(plain_byte());
        end else if (a < 52) begin
          add_byte(cur_cfg.escape_marker);
          add_byte(8'($urandom_range(0, 255)));
        end else if (a < 70 && lvl > 0 && lvl < 6) begin
          add_byte(cur_cfg.start_marker);
          add_byte(8'($urandom_range(0, 255)));
          lvl++;
        end else if (a < 90 && lvl > 1) begin
          add_byte(cur_cfg.end_marker);
          lvl--;
        end else if (a < 94) begin
          // May close the root early or close with nothing open.
          add_byte(cur_cfg.end_marker);
          if (lvl > 0) lvl--;
        end else if (a < 96) begin
          add_byte(cur_cfg.start_marker);
          add_byte(8'($urandom_range(0, 255)));
          if (lvl > 0) lvl++;
        end else begin
          add_byte(8'($urandom_range(0, 255)));
        end
      end
      a = $urandom_range(0, 99);
      if (a < 75) repeat (lvl) add_byte(cur_cfg.end_marker);
      else if (a < 85) repeat ($urandom_range(0, lvl)) add_byte(cur_cfg.end_marker);
      else if (a < 92) add_byte(cur_cfg.start_marker);
      else add_byte(cur_cfg.escape_marker);
    end
    flush_file();
  endtask

  // Nests children down to the depth bound, then tries one level more.
  task automatic gen_deep();
    repeat (4) add_byte(8'h00);
    add_byte(cur_cfg.start_marker);
    add_byte(8'($urandom_range(0, 255)));
    repeat (MAX_DEPTH - 1) begin
      add_byte(cur_cfg.start_marker);
      add_byte(8'($urandom_range(0, 255)));
    end
    add_byte(cur_cfg.start_marker);
    add_byte(plain_byte());
    flush_file();
  endtask

  task automatic run_phase(input logic [31:0] id, input logic [7:0] sm, input logic [7:0] em,
                           input logic [7:0] xm, input bit deep);
    write_reg(REG_ACCEPTED_ID, id);
    write_reg(REG_START_MARKER, {24'd0, sm});
    write_reg(REG_END_MARKER, {24'd0, em});
    write_reg(REG_ESCAPE_MARKER, {24'd0, xm});
    queued_cnt = 0;
    if (deep) gen_deep();
    while (queued_cnt < PHASE_BYTES) gen_file($urandom_range(2, 14));
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (rst);

    // Reset register values: wildcard id, escaped marker as a property, a child
    // whose type equals the end marker, then two closes.
    repeat (4) add_byte(8'h00);
    add_byte(START_MARKER_RST);
    add_byte(8'h07);
    add_byte(8'h41);
    add_byte(ESCAPE_MARKER_RST);
    add_byte(START_MARKER_RST);
    add_byte(START_MARKER_RST);
    add_byte(END_MARKER_RST);
    add_byte(END_MARKER_RST);
    add_byte(END_MARKER_RST);
    flush_file();
    // A one-byte file is too short.
    add_byte(8'hFF);
    flush_file();
    // Marker values inside the identifier are not markers; the bad id sticks.
    add_byte(START_MARKER_RST);
    add_byte(END_MARKER_RST);
    add_byte(ESCAPE_MARKER_RST);
    add_byte(8'h01);
    add_byte(START_MARKER_RST);
    add_byte(8'h05);
    add_byte(8'h00);
    add_byte(END_MARKER_RST);
    flush_file();
    wait_idle();

    run_phase(32'hFFFF_FFFF, 8'h00, 8'hFF, 8'h80, 1'b0);
    run_phase(32'h0000_0001, 8'hFF, 8'h00, 8'h7F, 1'b0);
    run_phase($urandom, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 1'b0);
    // End marker shadows the escape marker.
    run_phase($urandom, 8'h3C, 8'hC3, 8'hC3, 1'b0);
    // Start marker shadows the end marker, so no node can close.
    run_phase($urandom, 8'h5A, 8'h5A, 8'hA5, 1'b0);
    run_phase(32'd0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 1'b0);
    run_phase($urandom, START_MARKER_RST, END_MARKER_RST, ESCAPE_MARKER_RST, 1'b1);

    if (n_errors == 0)
      $display("** escaped_node_tree_deframer: PASSED **");
    else
      $display("** escaped_node_tree_deframer: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
rtl/entd_pkg.sv
rtl/entd_core.sv
rtl/entd_resq.sv
rtl/escaped_node_tree_deframer.sv
verif/tb.sv
